[hw/rtl/cson_pkg.sv]
package cson_pkg;

  // parse phases
  localparam logic [3:0] PhValue      = 4'd0;
  localparam logic [3:0] PhObjFirst   = 4'd1;
  localparam logic [3:0] PhKey        = 4'd2;
  localparam logic [3:0] PhAfterKey   = 4'd3;
  localparam logic [3:0] PhArrFirst   = 4'd4;
  localparam logic [3:0] PhArrNext    = 4'd5;
  localparam logic [3:0] PhAfterValue = 4'd6;
  localparam logic [3:0] PhString     = 4'd7;
  localparam logic [3:0] PhEsc        = 4'd8;
  localparam logic [3:0] PhHex1       = 4'd9;
  localparam logic [3:0] PhHex2       = 4'd10;
  localparam logic [3:0] PhHexBad     = 4'd11;
  localparam logic [3:0] PhSurrBs     = 4'd12;
  localparam logic [3:0] PhSurrU      = 4'd13;
  localparam logic [3:0] PhTail       = 4'd14;
  localparam logic [3:0] PhIgnore     = 4'd15;

  // event kinds
  localparam logic [2:0] EvObjOpen  = 3'd0;
  localparam logic [2:0] EvObjClose = 3'd1;
  localparam logic [2:0] EvArrOpen  = 3'd2;
  localparam logic [2:0] EvArrClose = 3'd3;
  localparam logic [2:0] EvStrByte  = 3'd4;
  localparam logic [2:0] EvStrEnd   = 3'd5;
  localparam logic [2:0] EvDone     = 3'd6;
  localparam logic [2:0] EvError    = 3'd7;

  // error codes
  localparam logic [3:0] ErrNone      = 4'd0;
  localparam logic [3:0] ErrExpect    = 4'd1;
  localparam logic [3:0] ErrEscape    = 4'd2;
  localparam logic [3:0] ErrHex       = 4'd3;
  localparam logic [3:0] ErrShortHex  = 4'd4;
  localparam logic [3:0] ErrNoSurr    = 4'd5;
  localparam logic [3:0] ErrBadSurr   = 4'd6;
  localparam logic [3:0] ErrLoneLow   = 4'd7;
  localparam logic [3:0] ErrUnterm    = 4'd8;
  localparam logic [3:0] ErrTooDeep   = 4'd9;
  localparam logic [3:0] ErrTrailing  = 4'd10;

  // configuration register indexes
  localparam logic [7:0] RegNestLimit = 8'd0;
  localparam logic [7:0] RegTrailComma = 8'd1;

  localparam int MaxRes    = 4;
  localparam int FifoDepth = 8;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload;
    logic       is_key;
    logic [3:0] code;
    logic       last;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  endfunction

  function automatic logic is_end(input logic [7:0] c);
    return (c == 8'h3d) || (c == 8'h2c) || (c == 8'h5d) || (c == 8'h7d) || is_ws(c);
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic result_t mk_res(input logic [2:0] kind, input logic [7:0] payload,
                                     input logic is_key, input logic [3:0] code);
    result_t r;
    r.kind = kind;
    r.payload = payload;
    r.is_key = is_key;
    r.code = code;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

[hw/rtl/cson_res_fifo.sv]
module cson_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         push_cnt_i,
  input  cson_pkg::result_t  push_data_i [cson_pkg::MaxRes],
  input  logic               pop_i,
  output cson_pkg::result_t  head_o,
  output logic [3:0]         count_o
);
  import cson_pkg::*;

  result_t    mem_q [FifoDepth];
  logic [2:0] wr_ptr_q, wr_ptr_d;
  logic [2:0] rd_ptr_q, rd_ptr_d;
  logic [3:0] count_q, count_d;
  logic       pop_ok;

  assign pop_ok  = pop_i && (count_q != 4'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + push_cnt_i;
    rd_ptr_d = rd_ptr_q + {2'b00, pop_ok};
    count_d  = count_q + {1'b0, push_cnt_i} - {3'b000, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // burst write of up to four results
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (3'(i) < push_cnt_i) begin
        mem_q[wr_ptr_q + 3'(i)] <= push_data_i[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 4'(FifoDepth)) else $error("result queue overflow");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok |=> rd_ptr_q == $past(rd_ptr_q) + 3'd1) else $error("read pointer stuck");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 3'd0 && !pop_ok) |=> count_q > $past(count_q))
    else $error("push lost");
`endif

endmodule

[hw/rtl/cson_text_parser.sv]
// A result item is written to the result queue when its input item is accepted.
// Throughput: one input item per cycle; results leave one per cycle while out_stall_i
// is low, from an eight-entry result queue, and input stalls while fewer than four
// entries are free. An item with a multi-byte escape yields up to four results.
// Reset is asynchronous: parser restarts, nesting_limit 100, trailing_comma_ok 0.
// The container stack memory is not cleared; entries are pushed before read.
module cson_text_parser #(
  parameter int MAX_DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_kind_o,
  output logic [7:0] payload_byte_o,
  output logic       is_key_o,
  output logic [3:0] error_code_o,
  output logic       last_of_run_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import cson_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(MAX_DEPTH);

  logic [6:0]    limit_q;
  logic          tc_q;
  logic [3:0]    ph_q, ph_d;
  logic [DW-1:0] dep_q, dep_d;
  logic          top_q, top_d;
  logic          key_q, key_d;
  logic [15:0]   hacc_q, hacc_d;
  logic [1:0]    hcnt_q, hcnt_d;
  logic [9:0]    hsur_q, hsur_d;
  logic          err_q, err_d;
  logic          push;
  logic [2:0]    nres;
  result_t       res [MaxRes];

  logic          stack_mem [MAX_DEPTH];
  logic          rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;

  logic          in_acc;
  logic [3:0]    fifo_cnt;
  result_t       head;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = fifo_cnt > 4'(FifoDepth - MaxRes);
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 7'd100;
      tc_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegNestLimit) limit_q <= cfg_data_i[6:0];
      else if (cfg_index_i == RegTrailComma) tc_q <= cfg_data_i[0];
    end
  end

  // one item: up to three chained phase steps (position, string, after)
  always_comb begin
    logic [7:0]    c;
    logic [3:0]    ph;
    logic [DW-1:0] dep;
    logic          top, key, err, go;
    logic [15:0]   hacc;
    logic [1:0]    hcnt;
    logic [9:0]    hsur;
    logic [2:0]    n;
    logic          a_close, a_bval, a_str, a_key, tos, obj;
    logic [4:0]    hv;
    logic [20:0]   cp;
    logic          cp_emit;
    c = text_byte_i;
    ph = ph_q; dep = dep_q; top = top_q; key = key_q; err = err_q;
    hacc = hacc_q; hcnt = hcnt_q; hsur = hsur_q;
    n = 3'd0; push = 1'b0; go = 1'b0;
    a_close = 1'b0; a_bval = 1'b0; a_str = 1'b0; a_key = 1'b0;
    obj = 1'b0; hv = hex_val(c); cp = '0; cp_emit = 1'b0; tos = 1'b0;
    for (int i = 0; i < MaxRes; i++) res[i] = mk_res(EvStrByte, 8'h00, 1'b0, ErrNone);

    if (end_of_text_i) begin
      if (!err) begin
        unique case (ph)
          PhTail, PhIgnore: res[0] = mk_res(EvDone, 8'h00, 1'b0, ErrNone);
          PhValue, PhArrFirst, PhArrNext:
            res[0] = mk_res(EvError, 8'h00, 1'b0,
                            (32'(dep) > 32'(limit_q)) ? ErrTooDeep : ErrUnterm);
          PhEsc: res[0] = mk_res(EvError, 8'h00, 1'b0, ErrEscape);
          PhHex1, PhHex2, PhHexBad: res[0] = mk_res(EvError, 8'h00, 1'b0, ErrShortHex);
          PhSurrBs, PhSurrU: res[0] = mk_res(EvError, 8'h00, 1'b0, ErrNoSurr);
          PhAfterKey, PhAfterValue: res[0] = mk_res(EvError, 8'h00, 1'b0, ErrExpect);
          default: res[0] = mk_res(EvError, 8'h00, 1'b0, ErrUnterm);
        endcase
        n = 3'd1;
      end
      ph = PhValue; dep = '0; key = 1'b0; err = 1'b0;
      hacc = '0; hcnt = '0; hsur = '0;
    end else begin
      go = !err;
      for (int p = 0; p < 3; p++) begin
        if (go) begin
          go = 1'b0; a_close = 1'b0; a_bval = 1'b0; a_str = 1'b0; a_key = 1'b0;
          cp_emit = 1'b0;
          tos = (dep != '0) && top;
          unique case (ph)
            PhValue: a_bval = !is_ws(c);
            PhObjFirst: begin
              if (!is_ws(c)) begin
                if (c == 8'h7d) a_close = 1'b1;
                else begin a_str = 1'b1; a_key = 1'b1; end
              end
            end
            PhKey: begin
              if (!is_ws(c)) begin
                if (tc_q && c == 8'h7d) a_close = 1'b1;
                else begin a_str = 1'b1; a_key = 1'b1; end
              end
            end
            PhAfterKey: begin
              if (!is_ws(c)) begin
                if (c == 8'h3d) ph = PhValue;
                else begin
                  res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrExpect);
                  n = n + 3'd1; err = 1'b1;
                end
              end
            end
            PhArrFirst: begin
              if (!is_ws(c)) begin
                if (c == 8'h5d) a_close = 1'b1; else a_bval = 1'b1;
              end
            end
            PhArrNext: begin
              if (!is_ws(c)) begin
                if (tc_q && c == 8'h5d) a_close = 1'b1; else a_bval = 1'b1;
              end
            end
            PhAfterValue: begin
              if (!is_ws(c)) begin
                if (c == 8'h2c) ph = tos ? PhKey : PhArrNext;
                else if (c == (tos ? 8'h7d : 8'h5d)) a_close = 1'b1;
                else begin
                  res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrExpect);
                  n = n + 3'd1; err = 1'b1;
                end
              end
            end
            PhString: begin
              if (is_end(c)) begin
                res[n[1:0]] = mk_res(EvStrEnd, 8'h00, key, ErrNone);
                n = n + 3'd1;
                if (key) ph = PhAfterKey;
                else ph = (dep == '0) ? PhTail : PhAfterValue;
                go = 1'b1;
              end else if (c == 8'h5c) begin
                ph = PhEsc;
              end else begin
                res[n[1:0]] = mk_res(EvStrByte, c, 1'b0, ErrNone);
                n = n + 3'd1;
              end
            end
            PhEsc: begin
              ph = PhString;
              priority case (c)
                8'h5c, 8'h3d, 8'h2c, 8'h5d, 8'h7d, 8'h2f, 8'h20: begin
                  res[n[1:0]] = mk_res(EvStrByte, c, 1'b0, ErrNone); n = n + 3'd1;
                end
                8'h62: begin res[n[1:0]] = mk_res(EvStrByte, 8'd8, 1'b0, ErrNone);
                  n = n + 3'd1; end
                8'h66: begin res[n[1:0]] = mk_res(EvStrByte, 8'd12, 1'b0, ErrNone);
                  n = n + 3'd1; end
                8'h6e: begin res[n[1:0]] = mk_res(EvStrByte, 8'd10, 1'b0, ErrNone);
                  n = n + 3'd1; end
                8'h72: begin res[n[1:0]] = mk_res(EvStrByte, 8'd13, 1'b0, ErrNone);
                  n = n + 3'd1; end
                8'h74: begin res[n[1:0]] = mk_res(EvStrByte, 8'd9, 1'b0, ErrNone);
                  n = n + 3'd1; end
                8'h75: begin ph = PhHex1; hacc = '0; hcnt = '0; end
                default: begin
                  res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrEscape);
                  n = n + 3'd1; err = 1'b1;
                end
              endcase
            end
            PhHex1, PhHex2: begin
              if (!hv[4]) begin
                hacc = {hacc[11:0], hv[3:0]};
                if (hcnt == 2'd3) begin
                  // four digits in: decide surrogate handling
                  if (ph == PhHex1) begin
                    if (hacc >= 16'hd800 && hacc <= 16'hdbff) begin
                      hsur = hacc[9:0]; ph = PhSurrBs;
                    end else if (hacc >= 16'hdc00 && hacc <= 16'hdfff) begin
                      res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrLoneLow);
                      n = n + 3'd1; err = 1'b1;
                    end else begin
                      cp = {5'd0, hacc}; cp_emit = 1'b1; ph = PhString;
                    end
                  end else if (hacc >= 16'hdc00 && hacc <= 16'hdfff) begin
                    cp = 21'h10000 + {1'b0, hsur, hacc[9:0]};
                    cp_emit = 1'b1; ph = PhString;
                  end else begin
                    res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrBadSurr);
                    n = n + 3'd1; err = 1'b1;
                  end
                end else begin
                  hcnt = hcnt + 2'd1;
                end
              end else if (hcnt == 2'd3) begin
                res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrHex);
                n = n + 3'd1; err = 1'b1;
              end else begin
                hcnt = hcnt + 2'd1; ph = PhHexBad;
              end
            end
            PhHexBad: begin
              if (hcnt == 2'd3) begin
                res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrHex);
                n = n + 3'd1; err = 1'b1;
              end else begin
                hcnt = hcnt + 2'd1;
              end
            end
            PhSurrBs: begin
              if (c == 8'h5c) ph = PhSurrU;
              else begin
                res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrNoSurr);
                n = n + 3'd1; err = 1'b1;
              end
            end
            PhSurrU: begin
              if (c == 8'h75) begin ph = PhHex2; hacc = '0; hcnt = '0; end
              else begin
                res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrNoSurr);
                n = n + 3'd1; err = 1'b1;
              end
            end
            PhTail: begin
              if (!is_ws(c)) begin
                if (c == 8'h00) ph = PhIgnore;
                else begin
                  res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrTrailing);
                  n = n + 3'd1; err = 1'b1;
                end
              end
            end
            default: ;
          endcase

          // utf-8 encode of a decoded code point
          if (cp_emit) begin
            if (cp < 21'h80) begin
              res[n[1:0]] = mk_res(EvStrByte, cp[7:0], 1'b0, ErrNone); n = n + 3'd1;
            end else if (cp < 21'h800) begin
              res[n[1:0]] = mk_res(EvStrByte, {3'b110, cp[10:6]}, 1'b0, ErrNone);
              res[n[1:0] + 2'd1] = mk_res(EvStrByte, {2'b10, cp[5:0]}, 1'b0, ErrNone);
              n = n + 3'd2;
            end else if (cp < 21'h10000) begin
              res[n[1:0]] = mk_res(EvStrByte, {4'b1110, cp[15:12]}, 1'b0, ErrNone);
              res[n[1:0] + 2'd1] = mk_res(EvStrByte, {2'b10, cp[11:6]}, 1'b0, ErrNone);
              res[n[1:0] + 2'd2] = mk_res(EvStrByte, {2'b10, cp[5:0]}, 1'b0, ErrNone);
              n = n + 3'd3;
            end else begin
              res[n[1:0]] = mk_res(EvStrByte, {5'b11110, cp[20:18]}, 1'b0, ErrNone);
              res[n[1:0] + 2'd1] = mk_res(EvStrByte, {2'b10, cp[17:12]}, 1'b0, ErrNone);
              res[n[1:0] + 2'd2] = mk_res(EvStrByte, {2'b10, cp[11:6]}, 1'b0, ErrNone);
              res[n[1:0] + 2'd3] = mk_res(EvStrByte, {2'b10, cp[5:0]}, 1'b0, ErrNone);
              n = n + 3'd4;
            end
          end

          // value start: depth check, container open or string
          if (a_bval) begin
            if (32'(dep) > 32'(limit_q)) begin
              res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrTooDeep);
              n = n + 3'd1; err = 1'b1;
            end else if (c == 8'h5b || c == 8'h7b) begin
              obj = (c == 8'h7b);
              if (32'(dep) >= MAX_DEPTH) begin
                res[n[1:0]] = mk_res(EvError, 8'h00, 1'b0, ErrTooDeep);
                n = n + 3'd1; err = 1'b1;
              end else begin
                push = 1'b1; top = obj; dep = dep + DW'(1);
                res[n[1:0]] = mk_res(obj ? EvObjOpen : EvArrOpen, 8'h00, 1'b0, ErrNone);
                n = n + 3'd1;
                ph = obj ? PhObjFirst : PhArrFirst;
              end
            end else begin
              a_str = 1'b1; a_key = 1'b0;
            end
          end

          // container close, new top comes from the prefetched entry
          if (a_close) begin
            res[n[1:0]] = mk_res(tos ? EvObjClose : EvArrClose, 8'h00, 1'b0, ErrNone);
            n = n + 3'd1;
            if (dep != '0) begin
              dep = dep - DW'(1); top = rd_q;
            end
            ph = (dep == '0) ? PhTail : PhAfterValue;
          end

          if (a_str) begin
            key = a_key; ph = PhString; go = 1'b1;
          end
        end
      end
    end

    if (n != 3'd0) res[n[1:0] - 2'd1].last = 1'b1;
    nres   = n;
    ph_d   = ph;
    dep_d  = dep;
    top_d  = top;
    key_d  = key;
    err_d  = err;
    hacc_d = hacc;
    hcnt_d = hcnt;
    hsur_d = hsur;
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhValue;
      dep_q  <= '0;
      top_q  <= 1'b0;
      key_q  <= 1'b0;
      err_q  <= 1'b0;
      hacc_q <= '0;
      hcnt_q <= '0;
      hsur_q <= '0;
    end else if (in_acc) begin
      ph_q   <= ph_d;
      dep_q  <= dep_d;
      top_q  <= top_d;
      key_q  <= key_d;
      err_q  <= err_d;
      hacc_q <= hacc_d;
      hcnt_q <= hcnt_d;
      hsur_q <= hsur_d;
    end
  end

  // container stack: entries below the top, next-to-top read ahead
  assign mem_we    = in_acc && push && (dep_q != '0);
  assign mem_waddr = AW'(dep_q - DW'(1));

  always_comb begin
    logic [DW-1:0] dnext;
    dnext = in_acc ? dep_d : dep_q;
    mem_raddr = (dnext >= DW'(2)) ? AW'(dnext - DW'(2)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[mem_waddr] <= top_q;
    if (mem_we && mem_waddr == mem_raddr) rd_q <= top_q;
    else rd_q <= stack_mem[mem_raddr];
  end

  cson_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (in_acc ? nres : 3'd0),
    .push_data_i (res),
    .pop_i       (!out_stall_i),
    .head_o      (head),
    .count_o     (fifo_cnt)
  );

  assign out_valid_o    = fifo_cnt != 4'd0;
  assign event_kind_o   = head.kind;
  assign payload_byte_o = head.payload;
  assign is_key_o       = head.is_key;
  assign error_code_o   = head.code;
  assign last_of_run_o  = head.last;

`ifndef SYNTHESIS
  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_text_i) |=> (dep_q == '0 && !err_q && ph_q == PhValue))
    else $error("end of text did not restart");
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(dep_q) <= MAX_DEPTH) else $error("stack depth overflow");
  a_quiet_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && err_q && !end_of_text_i) |-> nres == 3'd0)
    else $error("result after latched error");
  a_err_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !err_q && err_d) |-> res[nres[1:0] - 2'd1].kind == EvError)
    else $error("error latched without report");
`endif

endmodule
